[hw/rtl/apd_pkg.sv]
// Shared widths, constants, types and helpers of the four-stage allpass diffuser.
package apd_pkg;

  localparam int unsigned SW         = 24;        // sample width
  localparam int unsigned IW         = SW + 4;    // internal Q4.(SW-1) width
  localparam int unsigned ACCW       = IW + 2;    // sum of four stage outputs
  localparam int unsigned GAINW      = 16;
  localparam int unsigned GAIN_SHIFT = 18;
  localparam logic [GAINW-1:0] GAIN_CAP = 16'd57672;

  localparam int unsigned NUM_STAGES = 4;
  localparam int unsigned STAGE_LEN [NUM_STAGES] = '{997, 1453, 1987, 2741};

  function automatic int unsigned max_len();
    int unsigned m;
    m = 0;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (STAGE_LEN[i] > m) m = STAGE_LEN[i];
    end
    return m;
  endfunction

  localparam int unsigned MAX_LEN = max_len();
  localparam int unsigned AW      = $clog2(MAX_LEN);

  // Sample flowing down the stage chain with the running sum of stage outputs.
  typedef struct packed {
    logic                    valid;
    logic signed [IW-1:0]    x;
    logic signed [ACCW-1:0]  acc;
  } apd_flow_t;

  typedef struct packed {
    logic            we;
    logic [AW-1:0]   waddr;
    logic [IW-1:0]   wdata;
    logic            re;
    logic [AW-1:0]   raddr;
  } apd_ram_req_t;

  typedef struct packed {
    logic          busy;
    logic [AW-1:0] addr;
  } apd_clr_t;

  // Saturate a value one bit wider than the internal format.
  function automatic logic signed [IW-1:0] sat_int(logic signed [IW:0] v);
    logic signed [IW-1:0] r;
    if (v[IW] != v[IW-1]) begin
      r = v[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      r = v[IW-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/apd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module apd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/apd_stage.sv]
// One allpass stage: read delay word, form output, write back the feedback word.
module apd_stage import apd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  apd_clr_t            clr_i,
  input  logic [AW-1:0]       last_i,
  input  apd_flow_t           in_i,
  output apd_flow_t           out_o,
  output apd_ram_req_t        ram_req_o,
  input  logic [IW-1:0]       ram_rdata_i
);

  logic [AW-1:0]         ptr_q, ptr_d;
  logic                  v1_q, v2_q;
  logic                  fwd_q;
  logic [IW-1:0]         fwd_data_q;
  logic signed [IW-1:0]  x1_q, x2_q, y2_q;
  logic signed [ACCW-1:0] acc1_q, acc2_q;
  logic [AW-1:0]         a1_q, a2_q;

  logic signed [IW-1:0]  d;
  logic signed [IW:0]    neg_x;
  logic signed [IW:0]    y_sum;
  logic signed [IW-1:0]  y;
  logic signed [IW:0]    w_sum;
  logic signed [IW-1:0]  w;
  logic                  fwd_hit;

  // A write of the same entry at the sampling edge is not seen by the read.
  assign fwd_hit = in_i.valid && v2_q && (a2_q == ptr_q);

  assign d     = fwd_q ? $signed(fwd_data_q) : $signed(ram_rdata_i);
  assign neg_x = -$signed({x1_q[IW-1], x1_q});
  assign y_sum = (neg_x >>> 1) + $signed({d[IW-1], d});
  assign y     = sat_int(y_sum);

  assign w_sum = $signed({x2_q[IW-1], x2_q}) + $signed({y2_q[IW-1], y2_q[IW-1], y2_q[IW-1:1]});
  assign w     = sat_int(w_sum);

  always_comb begin
    if (!in_i.valid) begin
      ptr_d = ptr_q;
    end else if (ptr_q == last_i) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_comb begin
    if (clr_i.busy) begin
      ram_req_o.we    = (clr_i.addr <= last_i);
      ram_req_o.waddr = clr_i.addr;
      ram_req_o.wdata = '0;
      ram_req_o.re    = 1'b0;
      ram_req_o.raddr = clr_i.addr;
    end else begin
      ram_req_o.we    = v2_q && adv_i;
      ram_req_o.waddr = a2_q;
      ram_req_o.wdata = w;
      ram_req_o.re    = adv_i;
      ram_req_o.raddr = ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else if (adv_i) begin
      ptr_q <= ptr_d;
      v1_q  <= in_i.valid;
      v2_q  <= v1_q;
      fwd_q <= fwd_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_q       <= in_i.x;
      acc1_q     <= in_i.acc;
      a1_q       <= ptr_q;
      fwd_data_q <= w;
      x2_q       <= x1_q;
      y2_q       <= y;
      acc2_q     <= acc1_q;
      a2_q       <= a1_q;
    end
  end

  assign out_o.valid = v2_q;
  assign out_o.x     = y2_q;
  assign out_o.acc   = acc2_q + $signed({{(ACCW-IW){y2_q[IW-1]}}, y2_q});

endmodule

[hw/rtl/apd_out.sv]
// Tail gain scaling, output saturation and output register with skid stage.
module apd_out import apd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apd_flow_t         in_i,
  input  logic [GAINW-1:0]  gain_i,
  output logic              adv_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [SW-1:0]     m_axis_tdata
);

  localparam int unsigned PW = ACCW + GAINW + 1;

  logic                   av_q, pv_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [PW-1:0]   prod_d, prod_q, scaled;
  logic                   fits;
  logic [SW-1:0]          res;
  logic                   main_v_q, skid_v_q;
  logic [SW-1:0]          main_q, skid_q;

  assign adv_o  = !skid_v_q;
  assign prod_d = acc_q * $signed({1'b0, gain_i});
  assign scaled = prod_q >>> GAIN_SHIFT;
  assign fits   = (&scaled[PW-1:SW-1]) || !(|scaled[PW-1:SW-1]);

  always_comb begin
    if (fits) begin
      res = scaled[SW-1:0];
    end else if (scaled[PW-1]) begin
      res = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q     <= 1'b0;
      pv_q     <= 1'b0;
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      // pipeline holds; drain the skid into the output register
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else begin
      av_q <= in_i.valid;
      pv_q <= av_q;
      if (!main_v_q || m_axis_tready) begin
        main_v_q <= pv_q;
      end else if (pv_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        main_q <= skid_q;
      end
    end else begin
      acc_q  <= in_i.acc;
      prod_q <= prod_d;
      if (!main_v_q || m_axis_tready) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = main_v_q;
  assign m_axis_tdata  = main_q;

endmodule

[hw/rtl/allpass_diffuser_chain.sv]
// Four-stage allpass diffuser with tail gain: top level.
//
// Samples enter on the s_axis channel (24-bit signed, one per transaction)
// and leave on the m_axis channel, one result per input, in order.
// Each stage keeps its delay line in its own RAM; the read is issued as a
// sample enters the first stage register, the stage output is registered in
// the second, and the write-back word is formed from it. The tail registers
// the sum, then the gain product, then the output before m_axis shows it.
// Throughput is one sample per cycle while m_axis does not stall: every RAM
// sees one read and one write per sample on separate ports.
// The tail gain is written on the cfg channel (always ready) and clamped to
// 0.88 in Q0.16; write it only while no samples are in flight.
// After reset the delay RAMs are swept to zero, one address per cycle over
// the longest line of 2741 entries; s_axis_tready stays low until the sweep
// ends. When the receiver stalls, a skid register takes one more result and
// then the whole pipeline holds, so s_axis_tready drops.
module allpass_diffuser_chain import apd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SW-1:0]     s_axis_tdata,   // [23:0] sample_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [SW-1:0]     m_axis_tdata,   // [23:0] sample_out
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [GAINW-1:0]  cfg_data_i
);

  logic [GAINW-1:0] gain_q;
  logic             clr_busy_q;
  logic [AW-1:0]    clr_addr_q;
  apd_clr_t         clr;
  logic             adv;
  apd_flow_t        flow [NUM_STAGES+1];
  apd_ram_req_t     ram_req [NUM_STAGES];
  logic [IW-1:0]    ram_rdata [NUM_STAGES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_CAP;
    end else if (cfg_valid_i) begin
      gain_q <= (cfg_data_i > GAIN_CAP) ? GAIN_CAP : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(MAX_LEN - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  assign clr.busy = clr_busy_q;
  assign clr.addr = clr_addr_q;

  assign s_axis_tready = !clr_busy_q && adv;

  assign flow[0].valid = s_axis_tvalid && s_axis_tready;
  assign flow[0].x     = $signed({{(IW-SW){s_axis_tdata[SW-1]}}, s_axis_tdata});
  assign flow[0].acc   = '0;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    localparam int unsigned RamAw = $clog2(STAGE_LEN[g]);

    apd_ram #(
      .Width (IW),
      .Depth (STAGE_LEN[g])
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_req[g].we),
      .waddr_i (ram_req[g].waddr[RamAw-1:0]),
      .wdata_i (ram_req[g].wdata),
      .re_i    (ram_req[g].re),
      .raddr_i (ram_req[g].raddr[RamAw-1:0]),
      .rdata_o (ram_rdata[g])
    );

    apd_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .clr_i       (clr),
      .last_i      (AW'(STAGE_LEN[g] - 1)),
      .in_i        (flow[g]),
      .out_o       (flow[g+1]),
      .ram_req_o   (ram_req[g]),
      .ram_rdata_i (ram_rdata[g])
    );
  end

  apd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (flow[NUM_STAGES]),
    .gain_i        (gain_q),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[hw/rtl/apd_checker.sv]
// Port-level checks of the allpass diffuser, bound to the top level.
module apd_checker import apd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [SW-1:0]    m_axis_tdata
);

  logic       in_acc, out_acc;
  logic [4:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // count transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped or changed while stalled");

  a_sweep_blocks_input: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready during delay memory sweep");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 5'd0)
    else $error("result without a pending input");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 5'd12)
    else $error("more samples in flight than pipeline and skid can hold");

endmodule

bind allpass_diffuser_chain apd_checker u_apd_checker (.*);
